>>> sv/tpd_pkg.sv
package tpd_pkg;

	// Tree size and lifting depth.
	localparam int MAX_NODES = 1024;
	localparam int LEVELS    = 10;

	// Field widths of one item and one result.
	localparam int NODE_W   = 10;
	localparam int WEIGHT_W = 16;
	localparam int COST_W   = 32;
	localparam int STATUS_W = 2;
	localparam int DEPTH_W  = NODE_W;

	// Storage geometry.
	localparam int LVL_W   = $clog2(LEVELS);
	localparam int NADDR_W = $clog2(MAX_NODES);
	localparam int JDEPTH  = MAX_NODES * LEVELS;
	localparam int JADDR_W = $clog2(JDEPTH);

	// Nodes below this number (sentinel and root) are present from reset with zero depth and cost.
	localparam int RESET_NODES = 2;

	// Command and status codes.
	localparam logic CMD_LOAD = 1'b0;
	localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] ST_BAD_LOAD = 2'd1;
	localparam logic [STATUS_W-1:0] ST_UNLOADED = 2'd2;

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [LVL_W-1:0]   level_t;
	typedef logic [DEPTH_W-1:0] depth_t;
	typedef logic [COST_W-1:0]  cost_t;

	// Per-node record held in the node store.
	typedef struct packed {
		logic   loaded;
		depth_t depth;
		cost_t  cost;
	} node_rec_t;

	// Write request to the node store.
	typedef struct packed {
		logic      en;
		node_t     node;
		node_rec_t rec;
	} node_wr_t;

	// Write request to the ancestor table.
	typedef struct packed {
		logic   en;
		node_t  node;
		level_t level;
		node_t  data;
	} jump_wr_t;

	// True when a node number addresses a real table row.
	function automatic logic in_range(input node_t node);
		in_range = (32'(node) < MAX_NODES);
	endfunction

endpackage

>>> sv/tree_path_distance_lca_unit.sv
// Weighted tree store with lowest-common-ancestor and path-weight queries.
// Input channel: an item (cmd, node_a, node_b, edge_weight) is taken at a rising
// edge where start is high and busy is low. A load (cmd low) attaches node_a under
// the already present node_b with weight edge_weight; a query (cmd high) asks for
// the common ancestor of node_a and node_b and the weight of the path between them.
// Result channel: exactly one result per item, shown on ancestor_node, path_weight
// and status for a single cycle while done is high. The receiver cannot stall it.
// One item is in work at a time, and a new item may be started in the cycle in which
// done is shown. The ancestor table is a memory with a registered read port: a load
// reads one ancestor per level in turn, and a query reads one level per step in the
// lift and in the joint climb.
// After reset the node store is cleared one entry per cycle, and busy stays high until
// the clearing pass is done; only the sentinel (node 0) and the root (node 1) are present.
module tree_path_distance_lca_unit import tpd_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic                cmd,
	input  node_t               node_a,
	input  node_t               node_b,
	input  logic [WEIGHT_W-1:0] edge_weight,
	output logic                done,
	output node_t               ancestor_node,
	output cost_t               path_weight,
	output logic [STATUS_W-1:0] status
);

	typedef enum logic [13:0] {
		S_CLEAR   = 14'b00000000000001,
		S_IDLE    = 14'b00000000000010,
		S_CHK     = 14'b00000000000100,
		S_LROW    = 14'b00000000001000,
		S_LROW_W  = 14'b00000000010000,
		S_LIFT    = 14'b00000000100000,
		S_LIFT_W  = 14'b00000001000000,
		S_CMP     = 14'b00000010000000,
		S_CLIMB   = 14'b00000100000000,
		S_CLIMB_W = 14'b00001000000000,
		S_PAR     = 14'b00010000000000,
		S_PAR_W   = 14'b00100000000000,
		S_COST    = 14'b01000000000000,
		S_COST_W  = 14'b10000000000000
	} state_t;

	state_t              state_q;
	logic                cmd_q;
	node_t               a_q;
	node_t               b_q;
	node_t               cur_q;
	node_t               lca_q;
	logic [WEIGHT_W-1:0] w_q;
	level_t              k_q;
	depth_t              diff_q;
	cost_t               sum_q;
	logic                done_q;
	node_t               anc_q;
	cost_t               weight_q;
	logic [STATUS_W-1:0] status_q;

	node_t     nrd_a_node;
	node_rec_t ra;
	node_rec_t rb;
	node_wr_t  nwr;
	logic      ns_ready;

	node_t    jrd0_node;
	level_t   jrd0_level;
	node_t    jd0;
	node_t    jd1;
	jump_wr_t jwr;

	logic   load_ok;
	logic   query_ok;
	logic   [31:0] lift_step;
	logic   lift_take;
	level_t top_level;

	assign top_level = LVL_W'(LEVELS - 1);

	tpd_node_store u_node_store (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_a_node (nrd_a_node),
		.rd_b_node (node_b),
		.wr        (nwr),
		.rd_a_rec  (ra),
		.rd_b_rec  (rb),
		.ready     (ns_ready)
	);

	tpd_jump_store u_jump_store (
		.clk       (clk),
		.rd0_node  (jrd0_node),
		.rd0_level (jrd0_level),
		.rd1_node  (b_q),
		.rd1_level (k_q),
		.wr        (jwr),
		.rd0_data  (jd0),
		.rd1_data  (jd1)
	);

	// Item checks, evaluated while the node records of the latched item are on the read ports.
	assign load_ok  = in_range(b_q) && rb.loaded && in_range(a_q) && !ra.loaded;
	assign query_ok = in_range(a_q) && ra.loaded && in_range(b_q) && rb.loaded;

	// Greedy lift: climb 2^k levels while the depth gap still allows it.
	assign lift_step = 32'd1 << k_q;
	assign lift_take = (32'(diff_q) >= lift_step);

	// Node store reads: both item nodes at acceptance, the ancestor's cost at the end.
	assign nrd_a_node = (state_q == S_COST) ? lca_q : node_a;

	// Ancestor table reads. Port 0 follows the parent chain on a load and node a on a query.
	always_comb begin
		jrd0_node  = a_q;
		jrd0_level = k_q;
		case (state_q)
			S_LROW: begin
				jrd0_node  = cur_q;
				jrd0_level = LVL_W'(k_q - 1'b1);
			end
			S_PAR: begin
				jrd0_level = '0;
			end
			default: begin
				jrd0_node  = a_q;
				jrd0_level = k_q;
			end
		endcase
	end

	// Writes of a good load: the child's record, then its ancestor row level by level.
	// The row being read always belongs to an ancestor, never to the child being written.
	always_comb begin
		nwr            = '0;
		nwr.en         = (state_q == S_CHK) && (cmd_q == CMD_LOAD) && load_ok;
		nwr.node       = a_q;
		nwr.rec.loaded = 1'b1;
		nwr.rec.depth  = DEPTH_W'(rb.depth + 1'b1);
		nwr.rec.cost   = rb.cost + COST_W'(w_q);

		jwr       = '0;
		jwr.node  = a_q;
		if (state_q == S_LROW_W) begin
			jwr.en    = 1'b1;
			jwr.level = k_q;
			jwr.data  = jd0;
		end else begin
			jwr.en    = nwr.en;
			jwr.level = '0;
			jwr.data  = b_q;
		end
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_CLEAR;
			done_q   <= 1'b0;
			cmd_q    <= 1'b0;
			a_q      <= '0;
			b_q      <= '0;
			cur_q    <= '0;
			lca_q    <= '0;
			w_q      <= '0;
			k_q      <= '0;
			diff_q   <= '0;
			sum_q    <= '0;
			anc_q    <= '0;
			weight_q <= '0;
			status_q <= ST_OK;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				S_CLEAR: begin
					if (ns_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (start) begin
						cmd_q   <= cmd;
						a_q     <= node_a;
						b_q     <= node_b;
						w_q     <= edge_weight;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (cmd_q == CMD_LOAD) begin
						if (load_ok) begin
							cur_q   <= b_q;
							k_q     <= LVL_W'(1);
							state_q <= S_LROW;
						end else begin
							anc_q    <= '0;
							weight_q <= '0;
							status_q <= ST_BAD_LOAD;
							done_q   <= 1'b1;
							state_q  <= S_IDLE;
						end
					end else if (query_ok) begin
						// Keep the deeper node in a.
						if (ra.depth < rb.depth) begin
							a_q    <= b_q;
							b_q    <= a_q;
							diff_q <= rb.depth - ra.depth;
						end else begin
							diff_q <= ra.depth - rb.depth;
						end
						sum_q   <= ra.cost + rb.cost;
						k_q     <= top_level;
						state_q <= S_LIFT;
					end else begin
						anc_q    <= '0;
						weight_q <= '0;
						status_q <= ST_UNLOADED;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end
				end
				S_LROW: begin
					state_q <= S_LROW_W;
				end
				S_LROW_W: begin
					cur_q <= jd0;
					if (k_q == top_level) begin
						anc_q    <= '0;
						weight_q <= '0;
						status_q <= ST_OK;
						done_q   <= 1'b1;
						state_q  <= S_IDLE;
					end else begin
						k_q     <= k_q + 1'b1;
						state_q <= S_LROW;
					end
				end
				S_LIFT: begin
					if (lift_take) begin
						diff_q  <= diff_q - lift_step[DEPTH_W-1:0];
						state_q <= S_LIFT_W;
					end else if (k_q == '0) begin
						state_q <= S_CMP;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				S_LIFT_W: begin
					a_q <= jd0;
					if (k_q == '0) begin
						state_q <= S_CMP;
					end else begin
						k_q     <= k_q - 1'b1;
						state_q <= S_LIFT;
					end
				end
				S_CMP: begin
					if (a_q == b_q) begin
						lca_q   <= a_q;
						state_q <= S_COST;
					end else begin
						k_q     <= top_level;
						state_q <= S_CLIMB;
					end
				end
				S_CLIMB: begin
					state_q <= S_CLIMB_W;
				end
				S_CLIMB_W: begin
					// Climb together only while the ancestors still differ.
					if (jd0 != jd1) begin
						a_q <= jd0;
						b_q <= jd1;
					end
					if (k_q == '0) begin
						state_q <= S_PAR;
					end else begin
						k_q     <= k_q - 1'b1;
						state_q <= S_CLIMB;
					end
				end
				S_PAR: begin
					state_q <= S_PAR_W;
				end
				S_PAR_W: begin
					lca_q   <= jd0;
					state_q <= S_COST;
				end
				S_COST: begin
					state_q <= S_COST_W;
				end
				S_COST_W: begin
					anc_q    <= lca_q;
					weight_q <= sum_q - {ra.cost[COST_W-2:0], 1'b0};
					status_q <= ST_OK;
					done_q   <= 1'b1;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy          = (state_q != S_IDLE);
	assign done          = done_q;
	assign ancestor_node = anc_q;
	assign path_weight   = weight_q;
	assign status        = status_q;

`ifndef SYNTH
	// A result is shown for a single cycle and never twice for one item.
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for more than one cycle");

	// A result always follows a cycle of work.
	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result shown without an item in work");

	// Rejected items carry zero ancestor and weight (good loads do too, but are not checked here).
	a_reject_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != ST_OK)) |-> ((ancestor_node == '0) && (path_weight == '0)))
		else $error("rejected item returned a non-zero answer");
`endif

endmodule

>>> sv/tpd_node_store.sv
module tpd_node_store import tpd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  node_t     rd_a_node,
	input  node_t     rd_b_node,
	input  node_wr_t  wr,
	output node_rec_t rd_a_rec,
	output node_rec_t rd_b_rec,
	output logic      ready
);

	node_rec_t mem [MAX_NODES];

	logic               clr_q;
	logic [NADDR_W-1:0] clr_idx_q;
	node_rec_t          rd_a_q;
	node_rec_t          rd_b_q;
	logic               rd_a_low_q;
	logic               rd_b_low_q;
	node_rec_t          reset_rec;

	// Clearing pass after reset: one entry per cycle marks every node as absent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q     <= 1'b1;
			clr_idx_q <= '0;
		end else if (clr_q) begin
			clr_idx_q <= clr_idx_q + 1'b1;
			if (clr_idx_q == NADDR_W'(MAX_NODES - 1)) begin
				clr_q <= 1'b0;
			end
		end
	end

	// Single write port; the clearing pass owns it until it is done.
	always_ff @(posedge clk) begin
		if (clr_q) begin
			mem[clr_idx_q] <= '0;
		end else if (wr.en) begin
			mem[NADDR_W'(wr.node)] <= wr.rec;
		end
	end

	// Two registered read ports.
	always_ff @(posedge clk) begin
		rd_a_q     <= mem[NADDR_W'(rd_a_node)];
		rd_b_q     <= mem[NADDR_W'(rd_b_node)];
		rd_a_low_q <= (32'(rd_a_node) < RESET_NODES);
		rd_b_low_q <= (32'(rd_b_node) < RESET_NODES);
	end

	// The sentinel and the root are never written by a load and always read as present at depth zero.
	always_comb begin
		reset_rec        = '0;
		reset_rec.loaded = 1'b1;
	end

	assign rd_a_rec = rd_a_low_q ? reset_rec : rd_a_q;
	assign rd_b_rec = rd_b_low_q ? reset_rec : rd_b_q;
	assign ready    = !clr_q;

endmodule

>>> sv/tpd_jump_store.sv
module tpd_jump_store import tpd_pkg::*; (
	input  logic     clk,
	input  node_t    rd0_node,
	input  level_t   rd0_level,
	input  node_t    rd1_node,
	input  level_t   rd1_level,
	input  jump_wr_t wr,
	output node_t    rd0_data,
	output node_t    rd1_data
);

	node_t mem [JDEPTH];

	logic [JADDR_W-1:0] rd0_addr;
	logic [JADDR_W-1:0] rd1_addr;
	logic [JADDR_W-1:0] wr_addr;
	node_t              rd0_q;
	node_t              rd1_q;
	logic               rd0_low_q;
	logic               rd1_low_q;

	// Row-major layout: one row of LEVELS entries per node.
	assign rd0_addr = JADDR_W'(rd0_node) * JADDR_W'(LEVELS) + JADDR_W'(rd0_level);
	assign rd1_addr = JADDR_W'(rd1_node) * JADDR_W'(LEVELS) + JADDR_W'(rd1_level);
	assign wr_addr  = JADDR_W'(wr.node) * JADDR_W'(LEVELS) + JADDR_W'(wr.level);

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr_addr] <= wr.data;
		end
	end

	// Two registered read ports.
	always_ff @(posedge clk) begin
		rd0_q     <= mem[rd0_addr];
		rd1_q     <= mem[rd1_addr];
		rd0_low_q <= (32'(rd0_node) < RESET_NODES);
		rd1_low_q <= (32'(rd1_node) < RESET_NODES);
	end

	// Rows of the sentinel and the root point at the sentinel.
	assign rd0_data = rd0_low_q ? '0 : rd0_q;
	assign rd1_data = rd1_low_q ? '0 : rd1_q;

endmodule

>>> sim/tree_path_distance_lca_unit_test.sv
`timescale 1ns / 1ps

module tree_path_distance_lca_unit_test;
	import tpd_pkg::*;

	localparam logic CMD_QUERY    = !CMD_LOAD;
	localparam int   RESET_CYCLES = 7;
	localparam int   STALL_LIMIT  = 4000;
	localparam int   DRAIN_CYCLES = 60;
	localparam int   CHAIN_LOADS  = 520;
	localparam int   RANDOM_ITEMS = 420;

	// One answer of the block: ancestor, path weight and status code.
	typedef struct packed {
		node_t               anc;
		cost_t               weight;
		logic [STATUS_W-1:0] code;
	} tree_answer_t;

	logic                clk;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                cmd;
	node_t               node_a;
	node_t               node_b;
	logic [WEIGHT_W-1:0] edge_weight;
	logic                done;
	node_t               ancestor_node;
	cost_t               path_weight;
	logic [STATUS_W-1:0] status;

	// Shadow copy of the tree held by the block.
	node_t  lift_row [MAX_NODES][LEVELS];
	int     node_level [MAX_NODES];
	cost_t  cost_from_root [MAX_NODES];
	bit     is_present [MAX_NODES];
	node_t  present_nodes[$];

	tree_answer_t pending_answers[$];
	tree_answer_t oldest_answer;
	int           mismatches;
	int           stall_cycles;
	int           burst_left;

	tree_path_distance_lca_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.node_a(node_a),
		.node_b(node_b),
		.edge_weight(edge_weight),
		.done(done),
		.ancestor_node(ancestor_node),
		.path_weight(path_weight),
		.status(status)
	);

	always #5 clk = ~clk;

	// Lowest common ancestor by the same greedy lift and joint climb as the block.
	function automatic node_t lowest_common_ancestor(input node_t x, input node_t y);
		node_t hi;
		node_t lo;
		node_t t;
		int    k;
		hi = x;
		lo = y;
		if (node_level[hi] < node_level[lo]) begin
			t  = hi;
			hi = lo;
			lo = t;
		end
		for (k = LEVELS - 1; k >= 0; k--) begin
			if (node_level[hi] - node_level[lo] >= (1 << k))
				hi = lift_row[hi][k];
		end
		if (hi == lo)
			return hi;
		for (k = LEVELS - 1; k >= 0; k--) begin
			if (lift_row[hi][k] != lift_row[lo][k]) begin
				hi = lift_row[hi][k];
				lo = lift_row[lo][k];
			end
		end
		return lift_row[hi][0];
	endfunction

	// Applies one accepted item to the shadow tree and returns the answer it must give.
	function automatic tree_answer_t apply_tree_item(input logic op, input node_t a,
			input node_t b, input logic [WEIGHT_W-1:0] w);
		tree_answer_t ans;
		int           k;
		ans = '0;
		ans.code = ST_OK;
		if (op == CMD_LOAD) begin
			if (!(int'(b) < MAX_NODES && is_present[b]) || !(int'(a) < MAX_NODES) ||
					is_present[a]) begin
				ans.code = ST_BAD_LOAD;
			end else begin
				node_level[a]     = node_level[b] + 1;
				cost_from_root[a] = cost_from_root[b] + cost_t'(w);
				lift_row[a][0]    = b;
				for (k = 1; k < LEVELS; k++)
					lift_row[a][k] = lift_row[lift_row[a][k-1]][k-1];
				is_present[a] = 1'b1;
				present_nodes.insert(present_nodes.size(), a);
			end
		end else begin
			if (!(int'(a) < MAX_NODES && is_present[a]) ||
					!(int'(b) < MAX_NODES && is_present[b])) begin
				ans.code = ST_UNLOADED;
			end else begin
				ans.anc    = lowest_common_ancestor(a, b);
				ans.weight = cost_from_root[a] + cost_from_root[b] -
					(cost_from_root[ans.anc] << 1);
			end
		end
		return ans;
	endfunction

	// Gap before the next item: mostly short, a few long, with stretches of none.
	function automatic int pick_gap();
		int r;
		if (burst_left > 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 49) == 0) begin
			burst_left = $urandom_range(10, 40);
			return 0;
		end
		r = $urandom_range(0, 99);
		if (r < 40)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [WEIGHT_W-1:0] pick_weight();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 16)
			return '1;
		return WEIGHT_W'($urandom_range(0, 65535));
	endfunction

	function automatic node_t pick_present();
		return present_nodes[$urandom_range(0, present_nodes.size() - 1)];
	endfunction

	// A node not yet in the tree; falls back to any node once the tree is full.
	function automatic node_t pick_absent();
		node_t n;
		int    tries;
		n = node_t'($urandom_range(0, MAX_NODES - 1));
		for (tries = 0; tries < 4096 && is_present[n]; tries++)
			n = node_t'($urandom_range(0, MAX_NODES - 1));
		return n;
	endfunction

	// Presents one item after a random gap and holds it until the block takes it.
	task automatic send_item(input logic op, input node_t a, input node_t b,
			input logic [WEIGHT_W-1:0] w);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start       <= 1'b1;
		cmd         <= op;
		node_a      <= a;
		node_b      <= b;
		edge_weight <= w;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		pending_answers.insert(pending_answers.size(), apply_tree_item(op, a, b, w));
	endtask

	// Extremes of every field, both commands and each corner case by name.
	task automatic test_directed_cases();
		send_item(CMD_LOAD, 10'd1023, 10'd1, 16'hFFFF);
		send_item(CMD_LOAD, 10'd2, 10'd1023, 16'h0000);
		send_item(CMD_LOAD, 10'd512, 10'd1, 16'h1234);
		send_item(CMD_LOAD, 10'd3, 10'd2, 16'h8000);
		// Common ancestor at the root, then at one of the two nodes.
		send_item(CMD_QUERY, 10'd3, 10'd512, 16'h0000);
		send_item(CMD_QUERY, 10'd3, 10'd1023, 16'hFFFF);
		send_item(CMD_QUERY, 10'd1023, 10'd1023, 16'h0000);
		// Queries that involve the sentinel or the root.
		send_item(CMD_QUERY, 10'd0, 10'd3, 16'h0000);
		send_item(CMD_QUERY, 10'd1, 10'd0, 16'h0000);
		send_item(CMD_QUERY, 10'd0, 10'd0, 16'h0000);
		send_item(CMD_QUERY, 10'd1, 10'd1, 16'h0000);
		// Loads with a missing parent or an invalid child.
		send_item(CMD_LOAD, 10'd700, 10'd600, 16'h0001);
		send_item(CMD_LOAD, 10'd0, 10'd1, 16'h0002);
		send_item(CMD_LOAD, 10'd1, 10'd2, 16'h0003);
		send_item(CMD_LOAD, 10'd1023, 10'd512, 16'hFFFF);
		send_item(CMD_LOAD, 10'd1022, 10'd1022, 16'h0004);
		// Queries that name a node not in the tree, then one on two present nodes.
		send_item(CMD_QUERY, 10'd700, 10'd1, 16'h0000);
		send_item(CMD_QUERY, 10'd1, 10'd700, 16'h0000);
		send_item(CMD_QUERY, 10'd1022, 10'd1021, 16'h0000);
		send_item(CMD_QUERY, 10'd1023, 10'd512, 16'hFFFF);
	endtask

	// A long chain so that depth differences need the top lifting level.
	task automatic test_deep_chain();
		node_t chain[$];
		node_t tail;
		node_t child;
		int    i;
		tail = present_nodes[$];
		for (i = 0; i < CHAIN_LOADS; i++) begin
			child = pick_absent();
			send_item(CMD_LOAD, child, tail, pick_weight());
			chain.insert(chain.size(), child);
			tail = child;
		end
		send_item(CMD_QUERY, tail, 10'd512, 16'h0000);
		send_item(CMD_QUERY, 10'd1023, tail, 16'h0000);
		send_item(CMD_QUERY, tail, 10'd0, 16'h0000);
		for (i = 0; i < 40; i++) begin
			if (i % 2 == 0)
				send_item(CMD_QUERY, chain[$urandom_range(0, chain.size() - 1)],
					chain[$urandom_range(0, chain.size() - 1)], pick_weight());
			else
				send_item(CMD_QUERY, pick_present(),
					chain[$urandom_range(0, chain.size() - 1)], pick_weight());
		end
	endtask

	// Mostly good loads and queries on a growing tree, with a share of bad items.
	task automatic test_random_tree();
		int    i;
		int    r;
		node_t a;
		node_t parent;
		for (i = 0; i < RANDOM_ITEMS; i++) begin
			r = $urandom_range(0, 99);
			if (r < 40) begin
				if ($urandom_range(0, 3) == 0)
					parent = present_nodes[$];
				else
					parent = pick_present();
				send_item(CMD_LOAD, pick_absent(), parent, pick_weight());
			end else if (r < 80) begin
				a = pick_present();
				if ($urandom_range(0, 9) == 0)
					send_item(CMD_QUERY, a, a, pick_weight());
				else
					send_item(CMD_QUERY, a, pick_present(), pick_weight());
			end else if (r < 85) begin
				send_item(CMD_LOAD, pick_present(), pick_present(), pick_weight());
			end else if (r < 90) begin
				send_item(CMD_LOAD, node_t'($urandom_range(0, MAX_NODES - 1)),
					pick_absent(), pick_weight());
			end else if (r < 95) begin
				if ($urandom_range(0, 1) == 0)
					send_item(CMD_QUERY, pick_absent(), pick_present(), pick_weight());
				else
					send_item(CMD_QUERY, pick_present(), pick_absent(), pick_weight());
			end else begin
				send_item(logic'($urandom_range(0, 1)),
					node_t'($urandom_range(0, MAX_NODES - 1)),
					node_t'($urandom_range(0, MAX_NODES - 1)), pick_weight());
			end
		end
	endtask

	// Compares each result with the oldest answer still owed.
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_answers.size() == 0) begin
				$error("result with no item outstanding: ancestor_node %0d path_weight %0d status %0d",
					ancestor_node, path_weight, status);
				mismatches++;
			end else begin
				oldest_answer = pending_answers.pop_front();
				if (ancestor_node !== oldest_answer.anc) begin
					$error("ancestor_node: expected %0d, actual %0d",
						oldest_answer.anc, ancestor_node);
					mismatches++;
				end
				if (path_weight !== oldest_answer.weight) begin
					$error("path_weight: expected %0d, actual %0d",
						oldest_answer.weight, path_weight);
					mismatches++;
				end
				if (status !== oldest_answer.code) begin
					$error("status: expected %0d, actual %0d", oldest_answer.code, status);
					mismatches++;
				end
			end
		end
	end

	// Ends the run when neither an item nor a result moves for too long.
	always @(posedge clk) begin
		if ((start && !busy) || done)
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		clk            = 1'b0;
		arst_n        <= 1'b0;
		start         <= 1'b0;
		cmd           <= CMD_LOAD;
		node_a        <= '0;
		node_b        <= '0;
		edge_weight   <= '0;
		mismatches     = 0;
		stall_cycles   = 0;
		burst_left     = 0;
		for (int n = 0; n < MAX_NODES; n++) begin
			for (int k = 0; k < LEVELS; k++)
				lift_row[n][k] = '0;
			node_level[n]     = 0;
			cost_from_root[n] = '0;
			is_present[n]     = (n < RESET_NODES);
		end
		present_nodes.insert(present_nodes.size(), node_t'(0));
		present_nodes.insert(present_nodes.size(), node_t'(1));
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_cases();
		test_deep_chain();
		test_random_tree();

		// Let the last results arrive, then a little longer for stray ones.
		start <= 1'b0;
		while (pending_answers.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

>>> sim.f
sv/tpd_pkg.sv
sv/tpd_node_store.sv
sv/tpd_jump_store.sv
sv/tree_path_distance_lca_unit.sv
sim/tree_path_distance_lca_unit_test.sv
